// File: design/soh_pkg.sv
package soh_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 4096;
  localparam int FRAME_CAP = 4096;

  localparam int LEN_W = 13;
  localparam int IDX_W = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] SOH_CHAR = 8'h01;
  localparam logic [7:0] ACK_CHAR = 8'h06;
  localparam logic [7:0] NAK_CHAR = 8'h15;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_GOOD     = 3'd1;
  localparam logic [2:0] ST_BAD_LRC  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd1;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 13'd4096;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic [2:0]       frame_status;
    logic             reply_valid;
    logic [7:0]       reply_byte;
    logic [LEN_W-1:0] frame_length;
  } rsp_t;

  typedef struct packed {
    logic             long_length;
    logic [LEN_W-1:0] max_length;
  } cfg_t;

endpackage

// File: design/soh_deframer.sv
module soh_deframer #(
  parameter int MAX_PAYLOAD = soh_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  soh_pkg::req_t req,
  input  soh_pkg::cfg_t cfg,
  output soh_pkg::rsp_t result
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LEN0  = 3'd1;
  localparam logic [2:0] PH_LEN1  = 3'd2;
  localparam logic [2:0] PH_LEN2  = 3'd3;
  localparam logic [2:0] PH_LEN3  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_CHECK = 3'd6;

  localparam int CAP_INT = (MAX_PAYLOAD < soh_pkg::FRAME_CAP) ? MAX_PAYLOAD
                                                               : soh_pkg::FRAME_CAP;
  localparam logic [soh_pkg::LEN_W-1:0] CAP = soh_pkg::LEN_W'(CAP_INT);

  logic [2:0]                phase, phase_next;
  logic [31:0]               expected, expected_next;
  logic [soh_pkg::LEN_W-1:0] received, received_next;
  logic [7:0]                lrc, lrc_next;

  logic [soh_pkg::LEN_W-1:0] limit;
  logic [soh_pkg::LEN_W-1:0] received_inc;
  logic [31:0]               addend;
  logic [31:0]               length_sum;
  logic [7:0]                b;

  assign b = req.rx_byte;
  assign limit = (cfg.max_length > CAP) ? CAP : cfg.max_length;
  assign received_inc = received + soh_pkg::LEN_W'(1);

  // Place the header byte by phase; a mode flip mid-header shifts the layout.
  always_comb begin
    unique case (phase)
      PH_LEN1: addend = {16'd0, b, 8'd0};
      PH_LEN2: addend = cfg.long_length ? {8'd0, b, 16'd0} : {16'd0, b, 8'd0};
      PH_LEN3: addend = {b, 24'd0};
      default: addend = 32'd0;
    endcase
  end

  assign length_sum = expected + addend;

  always_comb begin
    phase_next    = phase;
    expected_next = expected;
    received_next = received;
    lrc_next      = lrc;
    result        = '0;

    if (req.cmd == soh_pkg::CMD_TIMEOUT) begin
      if (phase != PH_IDLE) result.frame_status = soh_pkg::ST_TIMEOUT;
      phase_next    = PH_IDLE;
      expected_next = '0;
      received_next = '0;
      lrc_next      = '0;
    end else begin
      case (phase)
        PH_LEN0: begin
          expected_next = {24'd0, b};
          lrc_next      = b;
          phase_next    = cfg.long_length ? PH_LEN1 : PH_LEN2;
        end
        PH_LEN1: begin
          lrc_next      = lrc ^ b;
          expected_next = length_sum;
          phase_next    = PH_LEN2;
        end
        PH_LEN2: begin
          lrc_next      = lrc ^ b;
          expected_next = length_sum;
          if (cfg.long_length) begin
            phase_next = PH_LEN3;
          end else if (length_sum != 32'd0) begin
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_IDLE;
            lrc_next   = '0;
          end
        end
        PH_LEN3: begin
          lrc_next      = lrc ^ b;
          expected_next = length_sum;
          if (length_sum != 32'd0) begin
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_IDLE;
            lrc_next   = '0;
          end
        end
        PH_DATA: begin
          if (received >= limit) begin
            // drop the byte and abort
            result.frame_status = soh_pkg::ST_OVERFLOW;
            phase_next    = PH_IDLE;
            expected_next = '0;
            received_next = '0;
            lrc_next      = '0;
          end else begin
            lrc_next             = lrc ^ b;
            result.payload_valid = 1'b1;
            result.payload_byte  = b;
            result.payload_index = received[soh_pkg::IDX_W-1:0];
            received_next        = received_inc;
            if ({19'd0, received_inc} == expected) phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          result.reply_valid = 1'b1;
          if (b == lrc) begin
            result.frame_status = soh_pkg::ST_GOOD;
            result.reply_byte   = soh_pkg::ACK_CHAR;
            result.frame_length = received;
          end else begin
            result.frame_status = soh_pkg::ST_BAD_LRC;
            result.reply_byte   = soh_pkg::NAK_CHAR;
          end
          phase_next    = PH_IDLE;
          expected_next = '0;
          received_next = '0;
          lrc_next      = '0;
        end
        default: begin
          phase_next    = (b == soh_pkg::SOH_CHAR) ? PH_LEN0 : PH_IDLE;
          expected_next = '0;
          received_next = '0;
          lrc_next      = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      expected <= '0;
      received <= '0;
      lrc      <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      expected <= expected_next;
      received <= received_next;
      lrc      <= lrc_next;
    end
  end

endmodule

// File: design/soh_skid.sv
module soh_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  soh_pkg::rsp_t result,
  output logic          full,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output soh_pkg::rsp_t rsp
);

  logic          skid_valid;
  soh_pkg::rsp_t skid;
  logic          out_free;

  assign out_free = !rsp_valid || !rsp_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) rsp <= skid;
      else if (load) rsp <= result;
    end else if (load) begin
      skid <= result;
    end
  end

endmodule

// File: design/soh_frame_receiver_unit.sv
// An accepted request's result is registered in rsp, or in skid if stalled.
// Throughput: one request per cycle unless req_stall; one result per request.
// A two-entry output buffer (result register plus skid) lets a request in
// while a result waits; req_stall rises only when both entries are held.
// Reset (synchronous, active high) returns the deframer to idle, empties the
// output buffer and sets long_length to 0 and max_length to 4096.
module soh_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = soh_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  soh_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output soh_pkg::rsp_t                 rsp,
  input  logic                          cfg_we,
  input  logic [soh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [soh_pkg::LEN_W-1:0]     cfg_data
);

  soh_pkg::cfg_t cfg;
  soh_pkg::rsp_t result;
  logic          accept;
  logic          full;

  assign req_stall = full;
  assign accept = req_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_length <= 1'b0;
      cfg.max_length  <= soh_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == soh_pkg::REG_LONG_LENGTH) cfg.long_length <= cfg_data[0];
      if (cfg_index == soh_pkg::REG_MAX_LENGTH) cfg.max_length <= cfg_data;
    end
  end

  soh_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_deframer (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .cfg    (cfg),
    .result (result)
  );

  soh_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .result    (result),
    .full      (full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> rsp_valid)
    else $error("accepted request produced no result");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("skid entry held while result register empty");

  a_reply_with_verdict: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.reply_valid) |->
      (rsp.frame_status == soh_pkg::ST_GOOD || rsp.frame_status == soh_pkg::ST_BAD_LRC))
    else $error("reply without LRC verdict");

  a_payload_no_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.payload_valid) |->
      (rsp.frame_status == soh_pkg::ST_NONE && !rsp.reply_valid))
    else $error("payload byte carries status");

endmodule
